@@ sv/palette_colour_fade_macros.svh @@
// ----------------------------------------------------------------------------
// palette colour fade assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef PALETTE_COLOUR_FADE_MACROS_SVH
`define PALETTE_COLOUR_FADE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PCF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("pcf port check failed");

// next-cycle implication, disabled during reset
`define PCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("pcf port check failed");

`endif

@@ sv/pcf_pkg.sv @@
// ----------------------------------------------------------------------------
// pcf_pkg
// types and constants for the palette colour fade block
// ----------------------------------------------------------------------------
`default_nettype none

package pcf_pkg;

    localparam int unsigned COLOUR_W   = 32;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_NIBBLE3  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NIBBLE4R = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BYTE8    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_POSITION = 1'd1;

    // reciprocal of 15 in 0.11 fixed point, exact for products up to 225
    localparam logic [7:0] RECIP_15   = 8'd137;
    localparam int unsigned RECIP_SHIFT = 11;
    localparam logic [3:0] STEP_MAX   = 4'hF;

    typedef struct packed {
        logic [COLOUR_W-1:0] source_colour;
        logic [COLOUR_W-1:0] target_colour;
        logic                last_entry;
    } t_in_word;

    typedef struct packed {
        logic [COLOUR_W-1:0] faded_colour;
        logic                last_out;
    } t_out_word;

endpackage

`default_nettype wire

@@ sv/pcf_nibble_fade.sv @@
// ----------------------------------------------------------------------------
// pcf_nibble_fade
// three nibble lanes, step/15 interpolation with optional bit rotation
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_nibble_fade (
    input  wire logic [11:0] i_src,
    input  wire logic [11:0] i_tgt,
    input  wire logic [3:0]  i_step,
    input  wire logic        i_rotated,
    output logic      [11:0] o_res
);
    import pcf_pkg::*;

    function automatic logic [3:0] rot_in(input logic [3:0] v);
        return {v[2:0], v[3]};
    endfunction

    function automatic logic [3:0] rot_out(input logic [3:0] v);
        return {v[0], v[3:1]};
    endfunction

    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic [3:0]        a;
        logic [3:0]        b;
        logic signed [4:0] diff;
        logic [3:0]        mag;
        logic [7:0]        prod;
        logic [15:0]       scaled;
        logic [3:0]        quo;
        logic [3:0]        sum;
        logic [3:0]        res;

        always_comb begin
            if (i_rotated) begin
                a = rot_in(i_src[4*g +: 4]);
                b = rot_in(i_tgt[4*g +: 4]);
            end else begin
                a = {1'b0, i_src[4*g +: 3]};
                b = {1'b0, i_tgt[4*g +: 3]};
            end
            diff   = $signed({1'b0, b}) - $signed({1'b0, a});
            mag    = diff[4] ? 4'(-diff) : diff[3:0];
            prod   = {4'b0, mag} * {4'b0, i_step};
            scaled = {8'b0, prod} * {8'b0, RECIP_15};
            quo    = scaled[RECIP_SHIFT +: 4];
            sum    = diff[4] ? (a - quo) : (a + quo);
            res    = i_rotated ? rot_out(sum) : {1'b0, sum[2:0]};
        end

        assign o_res[4*g +: 4] = res;
    end

endmodule

`default_nettype wire

@@ sv/pcf_byte_fade.sv @@
// ----------------------------------------------------------------------------
// pcf_byte_fade
// three byte lanes, src + (tgt - src) * pos / 256 wrapped to 8 bits
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_byte_fade (
    input  wire logic [31:0] i_src,
    input  wire logic [31:0] i_tgt,
    input  wire logic [15:0] i_pos,
    output logic      [31:0] o_res
);
    import pcf_pkg::*;

    logic [2:0][7:0] lane_res;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        // lanes sit at bits 24, 16 and 0
        localparam int unsigned SH = (g == 2) ? 0 : 24 - 8 * g;

        logic [7:0]  a;
        logic [7:0]  b;
        logic [15:0] diff;
        logic [15:0] prod;
        logic [7:0]  res;

        always_comb begin
            a    = i_src[SH +: 8];
            b    = i_tgt[SH +: 8];
            diff = {8'b0, b} - {8'b0, a};
            prod = diff * i_pos;
            res  = a + prod[15:8];
        end

        assign lane_res[g] = res;
    end

    assign o_res = {lane_res[0], lane_res[1], 8'b0, lane_res[2]};

endmodule

`default_nettype wire

@@ sv/palette_colour_fade.sv @@
// ----------------------------------------------------------------------------
// palette_colour_fade
// a word accepted at the input is held in the input register, then in the
// result register, from which it leaves as the output word
// throughput one palette entry per cycle when not stalled
// the per-entry logic between the two registers sets the clock rate
// reset: synchronous active-low, clears both valid flags, mode and position
// ----------------------------------------------------------------------------
`default_nettype none

module palette_colour_fade (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [pcf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pcf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire pcf_pkg::t_in_word           i_in_word,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output pcf_pkg::t_out_word               o_out_word
);
    import pcf_pkg::*;

    logic [MODE_W-1:0] r_colour_mode;
    logic [POS_W-1:0]  r_fade_position;
    logic              r_in_valid;
    t_in_word          r_in;
    logic              r_out_valid;
    t_out_word         r_out;
    t_out_word         n_out;

    logic        out_en;
    logic        in_en;
    logic [3:0]  step;
    logic [11:0] nib_res;
    logic [31:0] byte_res;

    assign out_en  = !r_out_valid || !i_stall;
    assign in_en   = !r_in_valid || out_en;
    assign o_stall = !in_en;
    assign o_valid = r_out_valid;
    assign o_out_word = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour_mode   <= MODE_NIBBLE3;
            r_fade_position <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLOUR_MODE:   r_colour_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_FADE_POSITION: r_fade_position <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_en) begin
                r_in_valid <= i_valid;
            end
            if (out_en) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_en && i_valid) begin
            r_in <= i_in_word;
        end
        if (out_en && r_in_valid) begin
            r_out <= n_out;
        end
    end

    // step saturates once the position reaches the target
    assign step = (|r_fade_position[15:8]) ? STEP_MAX : r_fade_position[7:4];

    pcf_nibble_fade u_nibble (
        .i_src     (r_in.source_colour[11:0]),
        .i_tgt     (r_in.target_colour[11:0]),
        .i_step    (step),
        .i_rotated (r_colour_mode == MODE_NIBBLE4R),
        .o_res     (nib_res)
    );

    pcf_byte_fade u_byte (
        .i_src (r_in.source_colour),
        .i_tgt (r_in.target_colour),
        .i_pos (r_fade_position),
        .o_res (byte_res)
    );

    always_comb begin
        n_out.last_out = r_in.last_entry;
        case (r_colour_mode)
            MODE_NIBBLE3:  n_out.faded_colour = {20'b0, nib_res};
            MODE_NIBBLE4R: n_out.faded_colour = {20'b0, nib_res};
            MODE_BYTE8:    n_out.faded_colour = byte_res;
            default:       n_out.faded_colour = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/pcf_checker.sv @@
// ----------------------------------------------------------------------------
// pcf_checker
// port-level checks on the palette colour fade handshakes
// ----------------------------------------------------------------------------
`default_nettype none

`include "palette_colour_fade_macros.svh"

module pcf_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pcf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pcf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_valid,
    input  wire logic                           o_stall,
    input  wire pcf_pkg::t_in_word              i_in_word,
    input  wire logic                           o_valid,
    input  wire logic                           i_stall,
    input  wire pcf_pkg::t_out_word             o_out_word
);
    import pcf_pkg::*;

    // a stalled result holds
    `PCF_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_out_word))

    // input only backs up when a result is waiting and stalled
    `PCF_ASSERT_IMPL(a_stall_needs_out, o_stall, o_valid && i_stall)

    // a free output side never stalls the input
    `PCF_ASSERT_IMPL(a_no_stall_free, !i_stall, !o_stall)

    // an accepted word passes the input and result registers to the output when the output is not stalled
    `PCF_ASSERT_NEXT(a_latency, (i_valid && !o_stall && !i_stall) ##1 !i_stall, o_valid)

endmodule

bind palette_colour_fade pcf_checker u_pcf_checker (.*);

`default_nettype wire
